>>> sv/esd_pkg.sv
// ----------------------------------------------------------------------------
// esd_pkg
// Shared constants and types for the EMA settling detector.
// ----------------------------------------------------------------------------
package esd_pkg;

    // default geometry
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF   = 16;

    // fixed-point formats of the config registers
    localparam int ALPHA_FRAC = 16;
    localparam int RATIO_FRAC = 24;

    localparam int AVG_BITS   = 32;
    localparam int INDEX_BITS = 8;

    // APB register map (word index)
    localparam int CFG_ADDR_BITS = 4;
    localparam logic [1:0] REG_ALPHA        = 2'd0;
    localparam logic [1:0] REG_STABLE_RATIO = 2'd1;
    localparam logic [1:0] REG_FIRST_CHECK  = 2'd2;
    localparam logic [1:0] REG_MAX_READS    = 2'd3;

    // reset values
    localparam logic [15:0] ALPHA_RESET        = 16'd13107;
    localparam logic [23:0] STABLE_RATIO_RESET = 24'd8389;
    localparam logic [7:0]  FIRST_CHECK_RESET  = 8'd2;
    localparam logic [7:0]  MAX_READS_RESET    = 8'd15;

    typedef struct packed {
        logic settled;
        logic timed_out;
    } esd_status_t;

endpackage

>>> sv/esd_datapath.sv
// ----------------------------------------------------------------------------
// esd_datapath
// One filter update and the settling / timeout decision for one reading.
// ----------------------------------------------------------------------------
module esd_datapath #(
    parameter int SAMPLE_BITS = esd_pkg::SAMPLE_BITS_DEF,
    parameter int FRAC_BITS   = esd_pkg::FRAC_BITS_DEF
) (
    input  logic signed [SAMPLE_BITS-1:0]     sample,
    input  logic                              start,
    input  logic signed [esd_pkg::AVG_BITS-1:0] prev_avg,
    input  logic [esd_pkg::INDEX_BITS-1:0]    read_count,
    input  logic [15:0]                       alpha,
    input  logic [23:0]                       stable_ratio,
    input  logic [7:0]                        first_check_read,
    input  logic [7:0]                        max_reads,
    output logic signed [esd_pkg::AVG_BITS-1:0] average,
    output logic [esd_pkg::INDEX_BITS-1:0]    read_index,
    output esd_pkg::esd_status_t              status
);
    import esd_pkg::*;

    localparam int DIFF_BITS = AVG_BITS + 2;
    localparam int PROD_BITS = DIFF_BITS + ALPHA_FRAC + 1;
    localparam int THR_BITS  = RATIO_FRAC + AVG_BITS;
    localparam int CMP_BITS  = DIFF_BITS + RATIO_FRAC;

    localparam logic signed [63:0] SAT_HI = 64'sd2147483647;
    localparam logic signed [63:0] SAT_LO = -64'sd2147483648;

    logic signed [63:0]           scaled;
    logic signed [AVG_BITS-1:0]   target;
    logic signed [DIFF_BITS-1:0]  diff;
    logic signed [PROD_BITS-1:0]  prod;
    logic signed [PROD_BITS-1:0]  prod_rnd;
    logic signed [DIFF_BITS-1:0]  delta;
    logic [DIFF_BITS-1:0]         abs_delta;
    logic [AVG_BITS-1:0]          abs_prev;
    logic [THR_BITS-1:0]          thresh;
    logic [CMP_BITS-1:0]          change;
    logic [7:0]                   last_idx;
    logic                         stable;

    // load value: sample in Q.FRAC_BITS, clipped to 32 bits
    assign scaled = 64'(sample) <<< FRAC_BITS;
    always_comb begin
        if (scaled > SAT_HI) begin
            target = AVG_BITS'(SAT_HI);
        end else if (scaled < SAT_LO) begin
            target = AVG_BITS'(SAT_LO);
        end else begin
            target = AVG_BITS'(scaled);
        end
    end

    assign diff     = DIFF_BITS'(target) - DIFF_BITS'(prev_avg);
    assign prod     = PROD_BITS'($signed({1'b0, alpha})) * PROD_BITS'(diff);
    // round to nearest, ties toward +inf
    assign prod_rnd = (prod + PROD_BITS'(1 << (ALPHA_FRAC - 1))) >>> ALPHA_FRAC;

    assign delta   = start ? diff : DIFF_BITS'(prod_rnd);
    assign average = AVG_BITS'(DIFF_BITS'(prev_avg) + delta);

    assign read_index = start ? '0 : read_count;

    // |avg - prev| * 2^24 < ratio * |prev|
    assign abs_delta = delta[DIFF_BITS-1] ? DIFF_BITS'(-delta) : DIFF_BITS'(delta);
    assign abs_prev  = prev_avg[AVG_BITS-1] ? AVG_BITS'(-prev_avg) : AVG_BITS'(prev_avg);
    assign thresh    = THR_BITS'(stable_ratio) * THR_BITS'(abs_prev);
    assign change    = CMP_BITS'(abs_delta) << RATIO_FRAC;

    assign stable = (read_index >= first_check_read) && (prev_avg != '0) &&
                    (change < CMP_BITS'(thresh));

    // a zero count behaves as one
    assign last_idx = (max_reads == 8'd0) ? 8'd0 : max_reads - 8'd1;

    assign status.settled   = stable;
    assign status.timed_out = !stable && (read_index >= last_idx);

endmodule

>>> sv/ema_settle_detector_unit.sv
// ----------------------------------------------------------------------------
// ema_settle_detector_unit
// Exponential moving average of sensor samples with settling detection.
// ----------------------------------------------------------------------------
// Usage:
//   Samples enter on the s_ stream (s_tdata = sample, s_tuser = window start).
//   A transaction with s_tuser set opens a window and loads the average with
//   the sample; later samples update the average by alpha (Q0.16). Each
//   reading inside an open window gives one m_ transaction: average and
//   reading index in m_tdata, settled / timed_out in m_tuser. Samples that
//   arrive with no window open are consumed and give nothing.
//   The input register loads on the s_ transaction and the result register
//   loads from it once the result register is free or being taken, which
//   raises m_tvalid. One sample is taken per cycle while the receiver keeps
//   up; the filter update and both multipliers sit between those two
//   registers, and the filter state loads together with the result register.
//   When the receiver stalls, the result register holds and the input
//   register fills, then s_tready drops until m_tready returns.
//   Reset empties both registers, closes any window, zeroes the average
//   history and loads the register defaults (alpha 0.2, ratio 0.05 percent,
//   first check at reading 2, timeout after 15 readings).
//   APB registers: 0x0 alpha, 0x4 stable_ratio, 0x8 first_check_read,
//   0xC max_reads. Write them only while the stream is idle.
// ----------------------------------------------------------------------------
module ema_settle_detector_unit #(
    parameter int SAMPLE_BITS = esd_pkg::SAMPLE_BITS_DEF,
    parameter int FRAC_BITS   = esd_pkg::FRAC_BITS_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // input stream
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]       s_tdata,  // [SAMPLE_BITS-1:0] sample
    input  logic                                   s_tuser,  // [0] window_start
    // result stream
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [39:0]                            m_tdata,  // [31:0] average, [39:32] read_index
    output logic [1:0]                             m_tuser,  // [0] settled, [1] timed_out
    // config port
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [esd_pkg::CFG_ADDR_BITS-1:0]      paddr,
    input  logic [31:0]                            pwdata,
    output logic [31:0]                            prdata,
    output logic                                   pready
);
    import esd_pkg::*;

    // config registers
    logic [15:0] alpha_reg;
    logic [23:0] ratio_reg;
    logic [7:0]  first_check_reg;
    logic [7:0]  max_reads_reg;
    logic        cfg_write;
    logic [1:0]  cfg_index;

    // input register
    logic                          in_valid_reg;
    logic signed [SAMPLE_BITS-1:0] in_sample_reg;
    logic                          in_start_reg;

    // filter state
    logic signed [AVG_BITS-1:0]    prev_avg_reg, prev_avg_next;
    logic [INDEX_BITS-1:0]         read_count_reg, read_count_next;
    logic                          window_open_reg, window_open_next;

    // result register
    logic                          out_valid_reg, out_valid_next;
    logic signed [AVG_BITS-1:0]    out_avg_reg;
    logic [INDEX_BITS-1:0]         out_index_reg;
    esd_status_t                   out_status_reg;

    logic                          advance;
    logic                          produce;
    logic signed [AVG_BITS-1:0]    dp_average;
    logic [INDEX_BITS-1:0]         dp_index;
    esd_status_t                   dp_status;
    logic                          ended;

    // ------------------------------------------------------------------
    // APB
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_index = paddr[3:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alpha_reg       <= ALPHA_RESET;
            ratio_reg       <= STABLE_RATIO_RESET;
            first_check_reg <= FIRST_CHECK_RESET;
            max_reads_reg   <= MAX_READS_RESET;
        end else if (cfg_write) begin
            unique case (cfg_index)
                REG_ALPHA:        alpha_reg       <= pwdata[15:0];
                REG_STABLE_RATIO: ratio_reg       <= pwdata[23:0];
                REG_FIRST_CHECK:  first_check_reg <= pwdata[7:0];
                REG_MAX_READS:    max_reads_reg   <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_index)
            REG_ALPHA:        prdata = 32'(alpha_reg);
            REG_STABLE_RATIO: prdata = 32'(ratio_reg);
            REG_FIRST_CHECK:  prdata = 32'(first_check_reg);
            REG_MAX_READS:    prdata = 32'(max_reads_reg);
            default:          prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Handshake
    // ------------------------------------------------------------------
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_sample_reg <= $signed(s_tdata[SAMPLE_BITS-1:0]);
            in_start_reg  <= s_tuser;
        end
    end

    // ------------------------------------------------------------------
    // Filter
    // ------------------------------------------------------------------
    esd_datapath #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .FRAC_BITS   (FRAC_BITS)
    ) u_datapath (
        .sample           (in_sample_reg),
        .start            (in_start_reg),
        .prev_avg         (prev_avg_reg),
        .read_count       (read_count_reg),
        .alpha            (alpha_reg),
        .stable_ratio     (ratio_reg),
        .first_check_read (first_check_reg),
        .max_reads        (max_reads_reg),
        .average          (dp_average),
        .read_index       (dp_index),
        .status           (dp_status)
    );

    assign produce = advance && (in_start_reg || window_open_reg);
    assign ended   = dp_status.settled || dp_status.timed_out;

    always_comb begin
        prev_avg_next    = prev_avg_reg;
        read_count_next  = read_count_reg;
        window_open_next = window_open_reg;
        if (produce) begin
            // a stable reading leaves the history untouched
            if (!dp_status.settled) begin
                prev_avg_next = dp_average;
            end
            window_open_next = !ended;
            read_count_next  = ended ? dp_index : dp_index + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_avg_reg    <= '0;
            read_count_reg  <= '0;
            window_open_reg <= 1'b0;
        end else begin
            prev_avg_reg    <= prev_avg_next;
            read_count_reg  <= read_count_next;
            window_open_reg <= window_open_next;
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    always_comb begin
        if (advance) begin
            out_valid_next = produce;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (produce) begin
            out_avg_reg    <= dp_average;
            out_index_reg  <= dp_index;
            out_status_reg <= dp_status;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_index_reg, out_avg_reg};
    assign m_tuser  = {out_status_reg.timed_out, out_status_reg.settled};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_one_end_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("settled and timed_out both set");

    a_end_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        (produce && ended) |=> !window_open_reg)
        else $error("window still open after final reading");

    a_start_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (produce && in_start_reg) |=> (m_tvalid && m_tdata[39:32] == '0))
        else $error("window start did not report reading zero");

    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready))
        else $error("input stalled without output backpressure");

    a_stable_keeps_prev: assert property (@(posedge aclk) disable iff (!aresetn)
        (produce && dp_status.settled) |=> $stable(prev_avg_reg))
        else $error("history changed on a stable reading");

endmodule
